// ===== src/brt_pkg.sv =====
package brt_pkg;

    localparam int SEC_SLOTS    = 6;
    localparam int SUB_SLOTS    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int MAX_SLOTS = (SEC_SLOTS > SUB_SLOTS) ? SEC_SLOTS : SUB_SLOTS;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SEC_W     = (SEC_SLOTS > 1) ? $clog2(SEC_SLOTS) : 1;
    localparam int SUB_W     = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;

    localparam int TYPE_W  = 8;
    localparam int ADDR_W  = 48;
    localparam int KEY_W   = TYPE_W + ADDR_W;
    localparam int HDL_W   = 16;
    localparam int IDXQ_W  = 4;
    localparam int PAY_W   = 64;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] OBJ_OUR_SEC  = 2'd0;
    localparam logic [1:0] OBJ_PEER_SEC = 2'd1;
    localparam logic [1:0] OBJ_SUB      = 2'd2;
    localparam logic [1:0] OBJ_UNSUP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOTSUP   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic rd;
        logic wr;
        logic del;
    } t_hits;

endpackage

// ===== src/brt_if.sv =====
interface brt_req_if;
    import brt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [1:0]        obj_kind;
    logic [TYPE_W-1:0] peer_type;
    logic [ADDR_W-1:0] dev_addr;
    logic [HDL_W-1:0]  attr_handle;
    logic [IDXQ_W-1:0] match_index;
    logic [PAY_W-1:0]  payload;

    modport source (output valid, kind, obj_kind, peer_type, dev_addr, attr_handle,
                    match_index, payload, input ready);
    modport sink   (input valid, kind, obj_kind, peer_type, dev_addr, attr_handle,
                    match_index, payload, output ready);
endinterface

interface brt_rsp_if;
    import brt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [TYPE_W-1:0] found_type;
    logic [ADDR_W-1:0] found_addr;
    logic [HDL_W-1:0]  found_handle;
    logic [PAY_W-1:0]  found_payload;
    logic              changed;

    modport source (output valid, status, found_type, found_addr, found_handle,
                    found_payload, changed, input ready);
    modport sink   (input valid, status, found_type, found_addr, found_handle,
                    found_payload, changed, output ready);
endinterface

// ===== src/bond_record_table_top.sv =====
// Bond record table: a security table of SEC_SLOTS entries and a subscription table of
// SUB_SLOTS entries, each with valid bits, serving read, write and delete requests one
// at a time. Once a request is taken, a single key/handle compare unit walks the
// selected table one slot per cycle. A read stops at its match, a write stops at an
// exact hit or goes on to a fill state that writes the lowest free slot (full if
// none), a delete always walks the whole table. An unsupported request skips the scan
// and goes straight from the idle state to the response state.
// The request side is not ready until the response transaction has completed.
module bond_record_table_top
    import brt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    brt_req_if.sink   i_req,
    brt_rsp_if.source o_rsp
);

    t_state r_state, n_state;

    // request capture
    logic [1:0]              r_kind;
    logic                    r_sub;
    logic                    r_any;
    logic [KEY_W-1:0]        r_key;
    logic [HDL_W-1:0]        r_handle;
    logic [IDXQ_W-1:0]       r_want;
    logic [PAYLOAD_BITS-1:0] r_pay;

    // scan state
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDXQ_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_free, n_free;
    logic              r_free_ok, n_free_ok;
    logic              r_hit, n_hit;

    // response
    logic [1:0]        r_status, n_status;
    logic [TYPE_W-1:0] r_ftype, n_ftype;
    logic [ADDR_W-1:0] r_faddr, n_faddr;
    logic [HDL_W-1:0]  r_fhdl, n_fhdl;
    logic [PAY_W-1:0]  r_fpay, n_fpay;
    logic              r_changed, n_changed;

    // tables
    logic [SEC_SLOTS-1:0]    r_sec_valid;
    logic [KEY_W-1:0]        r_sec_key  [SEC_SLOTS];
    logic [PAYLOAD_BITS-1:0] r_sec_data [SEC_SLOTS];
    logic [SUB_SLOTS-1:0]    r_sub_valid;
    logic [KEY_W-1:0]        r_sub_key  [SUB_SLOTS];
    logic [HDL_W-1:0]        r_sub_hdl  [SUB_SLOTS];
    logic [PAYLOAD_BITS-1:0] r_sub_data [SUB_SLOTS];

    logic             wr_data_en;
    logic             wr_key_en;
    logic             clr_en;
    logic [IDX_W-1:0] wr_slot;

    logic                    accept;
    logic                    req_bad;
    logic [SEC_W-1:0]        sec_idx;
    logic [SUB_W-1:0]        sub_idx;
    logic [IDX_W-1:0]        last_idx;
    logic                    is_last;
    t_entry                  ent;
    logic [PAYLOAD_BITS-1:0] ent_data;
    t_hits                   hits;

    assign accept  = i_req.valid && i_req.ready;
    assign req_bad = (i_req.obj_kind == OBJ_UNSUP) ||
                     !((i_req.kind == KIND_READ) || (i_req.kind == KIND_WRITE) ||
                       (i_req.kind == KIND_DELETE));

    assign sec_idx  = r_idx[SEC_W-1:0];
    assign sub_idx  = r_idx[SUB_W-1:0];
    assign last_idx = r_sub ? IDX_W'(SUB_SLOTS - 1) : IDX_W'(SEC_SLOTS - 1);
    assign is_last  = (r_idx == last_idx);

    always_comb begin
        if (r_sub) begin
            ent.valid  = r_sub_valid[sub_idx];
            ent.key    = r_sub_key[sub_idx];
            ent.handle = r_sub_hdl[sub_idx];
            ent_data   = r_sub_data[sub_idx];
        end else begin
            ent.valid  = r_sec_valid[sec_idx];
            ent.key    = r_sec_key[sec_idx];
            ent.handle = '0;
            ent_data   = r_sec_data[sec_idx];
        end
    end

    brt_match u_match (
        .i_ent    (ent),
        .i_key    (r_key),
        .i_handle (r_handle),
        .i_sub    (r_sub),
        .i_any    (r_any),
        .o_hits   (hits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_free     = r_free;
        n_free_ok  = r_free_ok;
        n_hit      = r_hit;
        n_status   = r_status;
        n_ftype    = r_ftype;
        n_faddr    = r_faddr;
        n_fhdl     = r_fhdl;
        n_fpay     = r_fpay;
        n_changed  = r_changed;
        wr_data_en = 1'b0;
        wr_key_en  = 1'b0;
        clr_en     = 1'b0;
        wr_slot    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx     = '0;
                    n_cnt     = '0;
                    n_free_ok = 1'b0;
                    n_hit     = 1'b0;
                    n_ftype   = '0;
                    n_faddr   = '0;
                    n_fhdl    = '0;
                    n_fpay    = '0;
                    n_changed = 1'b0;
                    if (req_bad) begin
                        n_status = ST_NOTSUP;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                case (r_kind)
                    KIND_READ: begin
                        if (hits.rd && (r_cnt == r_want)) begin
                            n_status = ST_OK;
                            n_ftype  = ent.key[KEY_W-1:ADDR_W];
                            n_faddr  = ent.key[ADDR_W-1:0];
                            n_fhdl   = r_sub ? ent.handle : '0;
                            n_fpay   = PAY_W'(ent_data);
                            n_state  = S_OUT;
                        end else begin
                            if (hits.rd) begin
                                n_cnt = r_cnt + 1'b1;
                            end
                            if (is_last) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_OUT;
                            end
                        end
                    end
                    KIND_WRITE: begin
                        if (hits.wr) begin
                            wr_data_en = 1'b1;
                            n_status   = ST_OK;
                            n_changed  = 1'b1;
                            n_state    = S_OUT;
                        end else begin
                            if (!ent.valid && !r_free_ok) begin
                                n_free    = r_idx;
                                n_free_ok = 1'b1;
                            end
                            if (is_last) begin
                                if (n_free_ok) begin
                                    n_state = S_FILL;
                                end else begin
                                    n_status = ST_FULL;
                                    n_state  = S_OUT;
                                end
                            end
                        end
                    end
                    KIND_DELETE: begin
                        if (hits.del) begin
                            clr_en = 1'b1;
                            n_hit  = 1'b1;
                        end
                        if (is_last) begin
                            n_status  = n_hit ? ST_OK : ST_NOTFOUND;
                            n_changed = n_hit;
                            n_state   = S_OUT;
                        end
                    end
                    default: begin
                        n_status = ST_NOTSUP;
                        n_state  = S_OUT;
                    end
                endcase
            end
            S_FILL: begin
                wr_slot    = r_free;
                wr_key_en  = 1'b1;
                wr_data_en = 1'b1;
                n_status   = ST_OK;
                n_changed  = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_req.kind;
            r_sub    <= (i_req.obj_kind == OBJ_SUB);
            r_key    <= {i_req.peer_type, i_req.dev_addr};
            r_any    <= ({i_req.peer_type, i_req.dev_addr} == '0);
            r_handle <= i_req.attr_handle;
            r_want   <= i_req.match_index;
            r_pay    <= i_req.payload[PAYLOAD_BITS-1:0];
        end
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_free    <= n_free;
        r_free_ok <= n_free_ok;
        r_hit     <= n_hit;
        r_status  <= n_status;
        r_ftype   <= n_ftype;
        r_faddr   <= n_faddr;
        r_fhdl    <= n_fhdl;
        r_fpay    <= n_fpay;
        r_changed <= n_changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_valid <= '0;
            r_sub_valid <= '0;
        end else begin
            if (r_sub) begin
                if (wr_key_en) begin
                    r_sub_valid[wr_slot[SUB_W-1:0]] <= 1'b1;
                end
                if (clr_en) begin
                    r_sub_valid[sub_idx] <= 1'b0;
                end
            end else begin
                if (wr_key_en) begin
                    r_sec_valid[wr_slot[SEC_W-1:0]] <= 1'b1;
                end
                if (clr_en) begin
                    r_sec_valid[sec_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sub) begin
            if (wr_key_en) begin
                r_sub_key[wr_slot[SUB_W-1:0]] <= r_key;
                r_sub_hdl[wr_slot[SUB_W-1:0]] <= r_handle;
            end
            if (wr_data_en) begin
                r_sub_data[wr_slot[SUB_W-1:0]] <= r_pay;
            end
        end else begin
            if (wr_key_en) begin
                r_sec_key[wr_slot[SEC_W-1:0]] <= r_key;
            end
            if (wr_data_en) begin
                r_sec_data[wr_slot[SEC_W-1:0]] <= r_pay;
            end
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.status        = r_status;
    assign o_rsp.found_type    = r_ftype;
    assign o_rsp.found_addr    = r_faddr;
    assign o_rsp.found_handle  = r_fhdl;
    assign o_rsp.found_payload = r_fpay;
    assign o_rsp.changed       = r_changed;

endmodule

// ===== src/brt_match.sv =====
module brt_match
    import brt_pkg::*;
(
    input  t_entry           i_ent,
    input  logic [KEY_W-1:0] i_key,
    input  logic [HDL_W-1:0] i_handle,
    input  logic             i_sub,
    input  logic             i_any,
    output t_hits            o_hits
);

    logic key_eq;
    logic hdl_eq;
    logic hdl_any;

    assign key_eq  = (i_ent.key == i_key);
    assign hdl_eq  = (i_ent.handle == i_handle);
    assign hdl_any = (i_handle == '0);

    // reads honor wildcard key and handle; writes exact, deletes match key only
    assign o_hits.rd  = i_ent.valid && (i_any || key_eq) && (!i_sub || hdl_any || hdl_eq);
    assign o_hits.wr  = i_ent.valid && key_eq && (!i_sub || hdl_eq);
    assign o_hits.del = i_ent.valid && key_eq;

endmodule

// ===== src/brt_checker.sv =====
module brt_checker
    import brt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic [1:0]        i_req_obj_kind,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [1:0]        i_rsp_status,
    input logic [ADDR_W-1:0] i_rsp_found_addr,
    input logic [PAY_W-1:0]  i_rsp_found_payload,
    input logic              i_rsp_changed
);

    // a stalled response transaction holds its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_found_payload) && $stable(i_rsp_changed))
        else $error("response changed while stalled");

    // one request in flight: no new request while a response is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request side ready with response pending");

    // unsupported object answers right away without touching the tables
    a_unsup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_obj_kind == OBJ_UNSUP) |=>
        i_rsp_valid && (i_rsp_status == ST_NOTSUP) && !i_rsp_changed)
        else $error("unsupported object not rejected");

    // only a successful request may change the table, and then no record is returned
    a_changed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_changed |-> (i_rsp_status == ST_OK) &&
        (i_rsp_found_payload == '0) && (i_rsp_found_addr == '0))
        else $error("changed flag on a failed request or a read");

    // failed requests return empty record fields
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |->
        (i_rsp_found_addr == '0) && (i_rsp_found_payload == '0))
        else $error("record fields set on a failed request");

endmodule

bind bond_record_table_top brt_checker u_brt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_req_obj_kind      (i_req.obj_kind),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_found_addr    (o_rsp.found_addr),
    .i_rsp_found_payload (o_rsp.found_payload),
    .i_rsp_changed       (o_rsp.changed)
);

// ===== bench/testbench.sv =====
module testbench
    import brt_pkg::*;
();

    localparam logic [1:0]       KIND_RSVD  = 2'd3;  // undefined request code
    localparam int               IDLE_PCT   = 7;
    localparam int               RAND_ITEMS = 1850;
    localparam int               STALL_MAX  = 3000;
    localparam int               DRAIN_CYC  = 20;
    localparam logic [PAY_W-1:0] PAY_MASK   = {PAY_W{1'b1}} >> (PAY_W - PAYLOAD_BITS);

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        obj_kind;
        logic [TYPE_W-1:0] peer_type;
        logic [ADDR_W-1:0] dev_addr;
        logic [HDL_W-1:0]  attr_handle;
        logic [IDXQ_W-1:0] match_index;
        logic [PAY_W-1:0]  payload;
    } brt_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TYPE_W-1:0] found_type;
        logic [ADDR_W-1:0] found_addr;
        logic [HDL_W-1:0]  found_handle;
        logic [PAY_W-1:0]  found_payload;
        logic              changed;
    } brt_rsp_t;

    // Shadow copy of both tables; row 0 is security, row 1 is subscription.
    class bond_table_shadow;
        bit               live[2][MAX_SLOTS];
        logic [KEY_W-1:0] keys[2][MAX_SLOTS];
        logic [HDL_W-1:0] hdls[2][MAX_SLOTS];
        logic [PAY_W-1:0] words[2][MAX_SLOTS];
        brt_rsp_t         awaited[$];
        int               failures;

        function new();
            failures = 0;
            foreach (live[t, i]) live[t][i] = 1'b0;
        endfunction

        function void note_request(brt_req_t r);
            brt_rsp_t         res;
            logic [KEY_W-1:0] key;
            bit               any_peer, subs, done;
            int               t, n, seen, free_slot;
            res       = '0;
            key       = {r.peer_type, r.dev_addr};
            any_peer  = (key == '0);
            subs      = (r.obj_kind == OBJ_SUB);
            t         = subs ? 1 : 0;
            n         = subs ? SUB_SLOTS : SEC_SLOTS;
            done      = 1'b0;
            seen      = 0;
            free_slot = -1;
            if (r.obj_kind == OBJ_UNSUP || r.kind == KIND_RSVD) begin
                res.status = ST_NOTSUP;
            end else if (r.kind == KIND_READ) begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (!done && live[t][i] && (any_peer || keys[t][i] == key) &&
                        (!subs || r.attr_handle == '0 || hdls[t][i] == r.attr_handle)) begin
                        if (seen < int'(r.match_index)) begin
                            seen++;
                        end else begin
                            done              = 1'b1;
                            res.status        = ST_OK;
                            res.found_type    = keys[t][i][KEY_W-1 -: TYPE_W];
                            res.found_addr    = keys[t][i][ADDR_W-1:0];
                            res.found_handle  = subs ? hdls[t][i] : '0;
                            res.found_payload = words[t][i];
                        end
                    end
                end
            end else if (r.kind == KIND_WRITE) begin
                for (int i = 0; i < n; i++) begin
                    if (!done) begin
                        if (!live[t][i]) begin
                            if (free_slot < 0) free_slot = i;
                        end else if (keys[t][i] == key &&
                                     (!subs || hdls[t][i] == r.attr_handle)) begin
                            words[t][i] = r.payload & PAY_MASK;
                            done        = 1'b1;
                        end
                    end
                end
                if (!done && free_slot >= 0) begin
                    live[t][free_slot]  = 1'b1;
                    keys[t][free_slot]  = key;
                    hdls[t][free_slot]  = r.attr_handle;
                    words[t][free_slot] = r.payload & PAY_MASK;
                    done                = 1'b1;
                end
                res.status  = done ? ST_OK : ST_FULL;
                res.changed = done;
            end else begin
                // delete matches on peer key alone, handle ignored
                for (int i = 0; i < n; i++) begin
                    if (live[t][i] && keys[t][i] == key) begin
                        live[t][i] = 1'b0;
                        done       = 1'b1;
                    end
                end
                res.status  = done ? ST_OK : ST_NOTFOUND;
                res.changed = done;
            end
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_response(brt_rsp_t got);
            brt_rsp_t want;
            if (awaited.size() == 0) begin
                $error("response transaction with no request outstanding");
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status",        64'(want.status),       64'(got.status));
            compare_field("found_type",    64'(want.found_type),   64'(got.found_type));
            compare_field("found_addr",    64'(want.found_addr),   64'(got.found_addr));
            compare_field("found_handle",  64'(want.found_handle), 64'(got.found_handle));
            compare_field("found_payload", want.found_payload,     got.found_payload);
            compare_field("changed",       64'(want.changed),      64'(got.changed));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   quiet_cycles;

    bond_table_shadow tables;
    logic [KEY_W-1:0] peer_pool[8];
    logic [HDL_W-1:0] handle_pool[5];

    brt_req_if req_bus ();
    brt_rsp_if rsp_bus ();

    bond_record_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                tables.note_request({req_bus.kind, req_bus.obj_kind, req_bus.peer_type,
                                     req_bus.dev_addr, req_bus.attr_handle,
                                     req_bus.match_index, req_bus.payload});
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                tables.check_response({rsp_bus.status, rsp_bus.found_type,
                                       rsp_bus.found_addr, rsp_bus.found_handle,
                                       rsp_bus.found_payload, rsp_bus.changed});
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic brt_req_t make_req(logic [1:0] kind, logic [1:0] obj,
                                          logic [KEY_W-1:0] key, logic [HDL_W-1:0] handle,
                                          logic [IDXQ_W-1:0] idx, logic [PAY_W-1:0] pay);
        brt_req_t r;
        r.kind        = kind;
        r.obj_kind    = obj;
        r.peer_type   = key[KEY_W-1 -: TYPE_W];
        r.dev_addr    = key[ADDR_W-1:0];
        r.attr_handle = handle;
        r.match_index = idx;
        r.payload     = pay;
        return r;
    endfunction

    function automatic brt_req_t rand_request();
        brt_req_t r;
        int       roll;
        r.payload = {$urandom, $urandom};
        roll = $urandom_range(99);
        r.kind = (roll < 38) ? KIND_READ : (roll < 75) ? KIND_WRITE :
                 (roll < 97) ? KIND_DELETE : KIND_RSVD;
        roll = $urandom_range(99);
        r.obj_kind = (roll < 4) ? OBJ_UNSUP : (roll < 36) ? OBJ_OUR_SEC :
                     (roll < 56) ? OBJ_PEER_SEC : OBJ_SUB;
        roll = $urandom_range(99);
        if (roll < 15) begin
            r.peer_type = 8'($urandom);
            r.dev_addr  = {16'($urandom), $urandom};
        end else if (r.kind == KIND_READ && roll < 35) begin
            {r.peer_type, r.dev_addr} = '0;  // wildcard peer
        end else begin
            {r.peer_type, r.dev_addr} = peer_pool[$urandom_range(7)];
        end
        r.attr_handle = ($urandom_range(99) < 15) ? 16'($urandom)
                                                  : handle_pool[$urandom_range(4)];
        r.match_index = ($urandom_range(99) < 75) ? 4'($urandom_range(2))
                                                  : 4'($urandom_range(15));
        return r;
    endfunction

    task automatic send_request(brt_req_t r);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.kind        <= r.kind;
        req_bus.obj_kind    <= r.obj_kind;
        req_bus.peer_type   <= r.peer_type;
        req_bus.dev_addr    <= r.dev_addr;
        req_bus.attr_handle <= r.attr_handle;
        req_bus.match_index <= r.match_index;
        req_bus.payload     <= r.payload;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    initial begin
        logic [KEY_W-1:0] key_max, key_b;
        logic [PAY_W-1:0] ones;
        key_max = '1;
        key_b   = {8'h01, 48'h0000_0000_0001};
        ones    = '1;

        tables       = new();
        quiet_cycles = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.kind        = KIND_READ;
        req_bus.obj_kind    = OBJ_OUR_SEC;
        req_bus.peer_type   = '0;
        req_bus.dev_addr    = '0;
        req_bus.attr_handle = '0;
        req_bus.match_index = '0;
        req_bus.payload     = '0;
        rsp_bus.ready       = 1'b0;

        peer_pool[0] = '0;
        peer_pool[1] = key_max;
        peer_pool[2] = {8'h00, 48'h0000_0000_0001};
        peer_pool[3] = {8'h01, 48'h8000_0000_0000};
        for (int i = 4; i < 8; i++) begin
            peer_pool[i] = {8'($urandom_range(1)), 16'($urandom), $urandom};
        end
        handle_pool[0] = '0;
        handle_pool[1] = 16'h0001;
        handle_pool[2] = 16'hFFFF;
        handle_pool[3] = 16'h8000;
        handle_pool[4] = 16'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, wildcard, overwrite, full, deletes, handle matching
        send_request(make_req(KIND_READ,   OBJ_OUR_SEC,  '0,      '0, 4'd0,  '0));
        send_request(make_req(KIND_WRITE,  OBJ_OUR_SEC,  key_max, '0, 4'd0,  ones));
        send_request(make_req(KIND_WRITE,  OBJ_PEER_SEC, '0,      '0, 4'd0,  '0));
        send_request(make_req(KIND_READ,   OBJ_OUR_SEC,  '0,      '0, 4'd0,  '0));
        send_request(make_req(KIND_READ,   OBJ_PEER_SEC, '0,      '0, 4'd1,  '0));
        send_request(make_req(KIND_READ,   OBJ_OUR_SEC,  '0,      '0, 4'd15, '0));
        send_request(make_req(KIND_WRITE,  OBJ_PEER_SEC, key_max, '0, 4'd0,
                              64'h5555_AAAA_5555_AAAA));
        send_request(make_req(KIND_READ,   OBJ_OUR_SEC,  key_max, '0, 4'd0,  '0));
        for (int i = 0; i < 5; i++) begin
            // fourth write fills the table, fifth finds it full
            send_request(make_req(KIND_WRITE, OBJ_OUR_SEC,
                                  {8'(8'h02 + i), 48'h0A5A_5A5A_5A00 + 48'(i)}, '0, 4'd0,
                                  {$urandom, $urandom}));
        end
        send_request(make_req(KIND_DELETE, OBJ_OUR_SEC,  key_max, '0, 4'd0,  '0));
        send_request(make_req(KIND_DELETE, OBJ_OUR_SEC,  key_max, '0, 4'd0,  '0));
        send_request(make_req(KIND_WRITE,  OBJ_SUB,      key_b, 16'hFFFF, 4'd0, ones));
        send_request(make_req(KIND_WRITE,  OBJ_SUB,      key_b, 16'h0001, 4'd0,
                              64'h0123_4567_89AB_CDEF));
        send_request(make_req(KIND_READ,   OBJ_SUB,      key_b, '0,       4'd1, '0));
        send_request(make_req(KIND_READ,   OBJ_SUB,      key_b, 16'hFFFF, 4'd0, '0));
        send_request(make_req(KIND_READ,   OBJ_SUB,      '0,    16'h0001, 4'd0, '0));
        send_request(make_req(KIND_DELETE, OBJ_SUB,      key_b, 16'h0005, 4'd0, '0));
        send_request(make_req(KIND_READ,   OBJ_SUB,      key_b, '0,       4'd0, '0));
        send_request(make_req(KIND_READ,   OBJ_UNSUP,    key_b, '0,       4'd0, '0));
        send_request(make_req(KIND_WRITE,  OBJ_UNSUP,    key_b, '0,       4'd0, ones));
        send_request(make_req(KIND_RSVD,   OBJ_OUR_SEC,  key_b, '0,       4'd0, '0));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 600 && n < 900);
            send_request(rand_request());
        end
        calm = 1'b0;
        req_bus.valid <= 1'b0;

        while (tables.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (tables.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
